FILE: design/assert_macros.svh
// Assertion macros shared by the noise gate RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SBNG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When pre holds, post must hold in the next cycle.
`define SBNG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/sbng_pkg.sv
// Types and constants of the spectral bin noise gate.
// No dependencies; used by spectral_bin_noise_gate_unit.
`default_nettype none

package sbng_pkg;

    // Input and output words
    typedef struct packed {
        logic [7:0]         bin;
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
        logic [14:0]        gain;
    } t_out;

    // Per-bin stored state
    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] noise;
    } t_bin_state;

    // Register indexes
    localparam logic CFG_NOISE_SHIFT = 1'b0;
    localparam logic CFG_FIXED_THR   = 1'b1;

    localparam logic [3:0] NOISE_SHIFT_RST = 4'd6;
    localparam logic [3:0] FIXED_THR_RST   = 4'd0;

    // Threshold classes
    localparam logic [1:0] CLS_TABLE = 2'd0;
    localparam logic [1:0] CLS_LOW   = 2'd1;
    localparam logic [1:0] CLS_HIGH  = 2'd2;

    localparam logic [14:0] UNITY      = 15'd32767;
    localparam logic [29:0] SNR_LOW    = 30'd18426;
    localparam logic [29:0] SNR_HIGH   = 30'd327670;
    localparam logic [18:0] THR_HIGH   = 19'd196602;
    localparam logic [18:0] THR_LOW    = 19'd32767;
    localparam logic [8:0]  TABLE_LAST = 9'd377;

    // Reciprocal of the SNR step of 818, scaled by 2^29
    localparam logic [19:0] IX_RCP     = 20'd656322;

    // Pipeline words
    typedef struct packed {
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic [14:0]        sig;
        logic [14:0]        nd;
    } t_ctx;

    typedef struct packed {
        t_ctx        ctx;
        logic [29:0] num;
        logic [14:0] rem;
        logic [29:0] quo;
    } t_d1;

    typedef struct packed {
        t_ctx        ctx;
        logic [1:0]  cls;
        logic [18:0] diff;
    } t_cls_word;

    typedef struct packed {
        t_ctx       ctx;
        logic [1:0] cls;
        logic [8:0] quo;
    } t_d2;

    typedef struct packed {
        t_ctx        ctx;
        logic [18:0] thr;
    } t_thr_word;

    typedef struct packed {
        t_ctx        ctx;
        logic [33:0] prod;
    } t_prod_word;

    typedef struct packed {
        t_ctx        ctx;
        logic [19:0] num;
        logic [14:0] rem;
        logic [19:0] quo;
    } t_d3;

    typedef struct packed {
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic [14:0]        gain;
    } t_gain_word;

    typedef struct packed {
        logic signed [31:0] pi;
        logic signed [31:0] pq;
        logic [14:0]        gain;
    } t_scaled_word;

    // Adaptive threshold versus SNR step
    localparam logic [17:0] THR_TABLE [0:377] = '{
        18'd196602, 18'd194126, 18'd191753, 18'd189476, 18'd187285, 18'd185176,
        18'd183143, 18'd181179, 18'd179281, 18'd177445, 18'd175665, 18'd173940,
        18'd172265, 18'd170639, 18'd169057, 18'd167518, 18'd166020, 18'd164560,
        18'd163137, 18'd161748, 18'd160393, 18'd159069, 18'd157775, 18'd156510,
        18'd155272, 18'd154061, 18'd152874, 18'd151713, 18'd150574, 18'd149458,
        18'd148363, 18'd147289, 18'd146234, 18'd145199, 18'd144183, 18'd143184,
        18'd142202, 18'd141237, 18'd140289, 18'd139355, 18'd138437, 18'd137534,
        18'd136644, 18'd135768, 18'd134906, 18'd134056, 18'd133219, 18'd132394,
        18'd131580, 18'd130779, 18'd129988, 18'd129208, 18'd128439, 18'd127680,
        18'd126931, 18'd126191, 18'd125462, 18'd124741, 18'd124029, 18'd123327,
        18'd122632, 18'd121947, 18'd121269, 18'd120599, 18'd119937, 18'd119283,
        18'd118636, 18'd117996, 18'd117364, 18'd116738, 18'd116119, 18'd115507,
        18'd114902, 18'd114303, 18'd113710, 18'd113123, 18'd112542, 18'd111967,
        18'd111397, 18'd110834, 18'd110276, 18'd109723, 18'd109176, 18'd108634,
        18'd108097, 18'd107565, 18'd107037, 18'd106515, 18'd105998, 18'd105485,
        18'd104977, 18'd104473, 18'd103973, 18'd103478, 18'd102988, 18'd102501,
        18'd102019, 18'd101540, 18'd101066, 18'd100596, 18'd100129, 18'd99666,
        18'd99207,  18'd98752,  18'd98300,  18'd97852,  18'd97407,  18'd96966,
        18'd96528,  18'd96093,  18'd95662,  18'd95234,  18'd94809,  18'd94387,
        18'd93969,  18'd93553,  18'd93141,  18'd92731,  18'd92325,  18'd91921,
        18'd91520,  18'd91122,  18'd90727,  18'd90334,  18'd89944,  18'd89557,
        18'd89172,  18'd88790,  18'd88411,  18'd88034,  18'd87659,  18'd87287,
        18'd86918,  18'd86550,  18'd86186,  18'd85823,  18'd85463,  18'd85105,
        18'd84749,  18'd84395,  18'd84044,  18'd83695,  18'd83348,  18'd83003,
        18'd82660,  18'd82319,  18'd81980,  18'd81643,  18'd81308,  18'd80975,
        18'd80644,  18'd80315,  18'd79988,  18'd79663,  18'd79340,  18'd79018,
        18'd78698,  18'd78380,  18'd78064,  18'd77749,  18'd77437,  18'd77126,
        18'd76816,  18'd76508,  18'd76202,  18'd75898,  18'd75595,  18'd75294,
        18'd74994,  18'd74696,  18'd74400,  18'd74105,  18'd73812,  18'd73520,
        18'd73229,  18'd72940,  18'd72653,  18'd72367,  18'd72082,  18'd71799,
        18'd71517,  18'd71237,  18'd70958,  18'd70680,  18'd70404,  18'd70129,
        18'd69855,  18'd69583,  18'd69312,  18'd69042,  18'd68773,  18'd68506,
        18'd68240,  18'd67975,  18'd67712,  18'd67449,  18'd67188,  18'd66928,
        18'd66670,  18'd66412,  18'd66156,  18'd65900,  18'd65646,  18'd65393,
        18'd65141,  18'd64891,  18'd64641,  18'd64392,  18'd64145,  18'd63898,
        18'd63653,  18'd63409,  18'd63165,  18'd62923,  18'd62682,  18'd62442,
        18'd62203,  18'd61964,  18'd61727,  18'd61491,  18'd61256,  18'd61022,
        18'd60788,  18'd60556,  18'd60325,  18'd60094,  18'd59865,  18'd59636,
        18'd59408,  18'd59182,  18'd58956,  18'd58731,  18'd58507,  18'd58283,
        18'd58061,  18'd57839,  18'd57619,  18'd57399,  18'd57180,  18'd56962,
        18'd56745,  18'd56528,  18'd56313,  18'd56098,  18'd55884,  18'd55671,
        18'd55458,  18'd55247,  18'd55036,  18'd54826,  18'd54617,  18'd54408,
        18'd54200,  18'd53993,  18'd53787,  18'd53582,  18'd53377,  18'd53173,
        18'd52969,  18'd52767,  18'd52565,  18'd52364,  18'd52163,  18'd51964,
        18'd51765,  18'd51566,  18'd51369,  18'd51172,  18'd50975,  18'd50780,
        18'd50585,  18'd50391,  18'd50197,  18'd50004,  18'd49812,  18'd49620,
        18'd49429,  18'd49239,  18'd49049,  18'd48860,  18'd48671,  18'd48483,
        18'd48296,  18'd48110,  18'd47924,  18'd47738,  18'd47553,  18'd47369,
        18'd47185,  18'd47002,  18'd46820,  18'd46638,  18'd46457,  18'd46276,
        18'd46096,  18'd45916,  18'd45737,  18'd45559,  18'd45381,  18'd45204,
        18'd45027,  18'd44851,  18'd44675,  18'd44500,  18'd44325,  18'd44151,
        18'd43978,  18'd43805,  18'd43632,  18'd43460,  18'd43289,  18'd43118,
        18'd42947,  18'd42777,  18'd42608,  18'd42439,  18'd42271,  18'd42103,
        18'd41935,  18'd41768,  18'd41602,  18'd41436,  18'd41271,  18'd41106,
        18'd40941,  18'd40777,  18'd40613,  18'd40450,  18'd40288,  18'd40125,
        18'd39964,  18'd39803,  18'd39642,  18'd39481,  18'd39321,  18'd39162,
        18'd39003,  18'd38844,  18'd38686,  18'd38529,  18'd38371,  18'd38215,
        18'd38058,  18'd37902,  18'd37747,  18'd37592,  18'd37437,  18'd37283,
        18'd37129,  18'd36975,  18'd36822,  18'd36670,  18'd36518,  18'd36366,
        18'd36214,  18'd36063,  18'd35913,  18'd35763,  18'd35613,  18'd35463,
        18'd35314,  18'd35166,  18'd35018,  18'd34870,  18'd34722,  18'd34575,
        18'd34428,  18'd34282,  18'd34136,  18'd33991,  18'd33845,  18'd33701,
        18'd33556,  18'd33412,  18'd33268,  18'd33125,  18'd32982,  18'd32839
    };

endpackage

`default_nettype wire

FILE: design/sbng_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sbng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/spectral_bin_noise_gate_unit.sv
// Spectral bin noise gate: per-bin signal/noise tracking and Q15 gain.
// Depends on sbng_pkg, sbng_ram and assert_macros.svh.
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------
//  input    | i_valid / o_stall      | i_data (bin, in_i, in_q)
//  output   | o_valid / i_stall      | o_data (out_i, out_q, gain)
//  config   | i_cfg_wr_en            | i_cfg_index, i_cfg_wdata
//
// One word per cycle sustained while neither i_stall nor the clearing pass
// holds the flow. The pipeline holds the 30-bit SNR divider (15 stages), the
// one-stage table index multiply and the 20-bit gain divider (10 stages). The
// per-bin state RAM is read as a word is accepted and written back from the
// accept register, with a one-entry forward for back-to-back same-bin words.
// After reset a clearing pass zeroes every RAM entry in turn; o_stall is high
// meanwhile. i_stall with a full output register freezes the whole pipeline.
`default_nettype none
`include "assert_macros.svh"

module spectral_bin_noise_gate_unit #(
    parameter int BINS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sbng_pkg::t_in     i_data,
    output logic              o_stall,
    output logic              o_valid,
    output sbng_pkg::t_out    o_data,
    input  logic              i_stall,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [3:0]        i_cfg_wdata
);

    localparam int AW       = $clog2(BINS);
    // Reciprocal of BINS scaled by 2^16; exact for every 8-bit bin index
    localparam int WRAP_RCP = (65536 + BINS - 1) / BINS;

    // Pipeline geometry
    localparam int D1_ST  = 15;
    localparam int D1_BPS = 2;
    localparam int D2_ST  = 1;
    localparam int D3_ST  = 10;
    localparam int D3_BPS = 2;
    localparam int V_A    = 0;
    localparam int V_B    = 1;
    localparam int V_C    = V_B + 1 + D1_ST;
    localparam int V_D    = V_C + 1 + D2_ST;
    localparam int V_E    = V_D + 1;
    localparam int V_F    = V_E + 1 + D3_ST;
    localparam int V_G    = V_F + 1;
    localparam int LAT    = V_G + 2;

    typedef struct packed {
        logic [AW-1:0]      addr;
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic [16:0]        mag;
    } t_sa;

    // Wrap the bin index modulo BINS by reciprocal multiplication.
    function automatic logic [AW-1:0] bin_wrap(input logic [7:0] b);
        logic [23:0] prod;
        logic [20:0] quo_bins;
        logic [20:0] rem;
        prod     = {16'd0, b} * 24'(WRAP_RCP);
        quo_bins = {13'd0, prod[23:16]} * 21'(BINS);
        rem      = {13'd0, b} - quo_bins;
        return rem[AW-1:0];
    endfunction

    // SNR divider: s*32767 / nd
    function automatic sbng_pkg::t_d1 d1_stage(input sbng_pkg::t_d1 x);
        sbng_pkg::t_d1 y;
        logic [15:0]   r;
        y = x;
        for (int k = 0; k < D1_BPS; k++) begin
            r     = {y.rem, y.num[29]};
            y.num = {y.num[28:0], 1'b0};
            if (r >= {1'b0, y.ctx.nd}) begin
                r     = r - {1'b0, y.ctx.nd};
                y.quo = {y.quo[28:0], 1'b1};
            end else begin
                y.quo = {y.quo[28:0], 1'b0};
            end
            y.rem = r[14:0];
        end
        return y;
    endfunction

    // Gain divider: thr*nd / s
    function automatic sbng_pkg::t_d3 d3_stage(input sbng_pkg::t_d3 x);
        sbng_pkg::t_d3 y;
        logic [15:0]   r;
        y = x;
        for (int k = 0; k < D3_BPS; k++) begin
            r     = {y.rem, y.num[19]};
            y.num = {y.num[18:0], 1'b0};
            if (r >= {1'b0, y.ctx.sig}) begin
                r     = r - {1'b0, y.ctx.sig};
                y.quo = {y.quo[18:0], 1'b1};
            end else begin
                y.quo = {y.quo[18:0], 1'b0};
            end
            y.rem = r[14:0];
        end
        return y;
    endfunction

    // Control
    logic           adv;
    logic           acc;
    logic [LAT-1:0] r_vld;
    logic           r_clr_busy;
    logic [AW-1:0]  r_clr_addr;
    logic [3:0]     r_noise_shift;
    logic [3:0]     r_fixed_thr;

    // Stage registers
    t_sa                    r_a, n_a;
    sbng_pkg::t_ctx         r_b, n_b;
    sbng_pkg::t_d1          r_d1 [D1_ST];
    sbng_pkg::t_d1          n_d1 [D1_ST];
    sbng_pkg::t_cls_word    r_c, n_c;
    sbng_pkg::t_d2          r_d2 [D2_ST];
    sbng_pkg::t_d2          n_d2 [D2_ST];
    sbng_pkg::t_thr_word    r_d, n_d;
    sbng_pkg::t_prod_word   r_e, n_e;
    sbng_pkg::t_d3          r_d3 [D3_ST];
    sbng_pkg::t_d3          n_d3 [D3_ST];
    sbng_pkg::t_gain_word   r_f, n_f;
    sbng_pkg::t_scaled_word r_g, n_g;
    sbng_pkg::t_out         r_out, n_out;

    // State RAM and forwarding
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    sbng_pkg::t_bin_state ram_wdata;
    sbng_pkg::t_bin_state ram_rdata;
    sbng_pkg::t_bin_state cur_state;
    sbng_pkg::t_bin_state upd_state;
    logic                 r_fwd_v;
    logic [AW-1:0]        r_fwd_addr;
    sbng_pkg::t_bin_state r_fwd_word;

    // Handshake: advance whenever the output register is free or drains.
    assign adv     = !r_vld[LAT-1] || !i_stall;
    assign o_stall = r_clr_busy || !adv;
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;

    // Accept stage: wrap the bin and estimate the magnitude.
    always_comb begin
        logic [16:0] xi_ext;
        logic [16:0] xq_ext;
        logic [16:0] ai;
        logic [16:0] aq;
        logic [16:0] hi;
        logic [16:0] lo;
        xi_ext  = {i_data.in_i[15], i_data.in_i};
        xq_ext  = {i_data.in_q[15], i_data.in_q};
        ai      = xi_ext[16] ? (17'd0 - xi_ext) : xi_ext;
        aq      = xq_ext[16] ? (17'd0 - xq_ext) : xq_ext;
        hi      = (ai > aq) ? ai : aq;
        lo      = (ai > aq) ? aq : ai;
        n_a.addr = bin_wrap(i_data.bin);
        n_a.in_i = i_data.in_i;
        n_a.in_q = i_data.in_q;
        n_a.mag  = hi + {2'b00, lo[16:2]};
    end

    // Re-read the held bin while frozen so the read data stays valid.
    assign ram_raddr = adv ? n_a.addr : r_a.addr;

    // Read-modify-write of the bin state.
    always_comb begin
        logic [19:0] sum;
        logic [16:0] s_raw;
        logic [14:0] s_new;
        logic [29:0] cap;
        logic [32:0] n_inc;
        logic [29:0] n_new;
        logic [29:0] nd_full;
        cur_state = (r_fwd_v && (r_fwd_addr == r_a.addr)) ? r_fwd_word : ram_rdata;
        sum   = {1'b0, cur_state.sig, 3'b000} - {4'b0000, cur_state.sig}
              + {3'b000, r_a.mag};
        s_raw = sum[19:3];
        s_new = (s_raw > {2'b00, sbng_pkg::UNITY}) ? sbng_pkg::UNITY : s_raw[14:0];
        cap   = {15'd0, s_new} << r_noise_shift;
        n_inc = {1'b0, cur_state.noise} + 33'd1;
        n_new = (n_inc > {3'b000, cap}) ? cap : n_inc[29:0];
        nd_full = n_new >> r_noise_shift;
        upd_state.sig   = {1'b0, s_new};
        upd_state.noise = {2'b00, n_new};
        n_b.in_i = r_a.in_i;
        n_b.in_q = r_a.in_q;
        n_b.sig  = s_new;
        n_b.nd   = nd_full[14:0];
    end

    assign ram_we    = r_clr_busy || (adv && r_vld[V_A]);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_a.addr;
    assign ram_wdata = r_clr_busy ? '0 : upd_state;

    sbng_ram #(
        .WIDTH ($bits(sbng_pkg::t_bin_state)),
        .DEPTH (BINS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // SNR divider stages.
    always_comb begin
        sbng_pkg::t_d1 init;
        init.ctx = r_b;
        init.num = {r_b.sig, 15'd0} - {15'd0, r_b.sig};
        init.rem = '0;
        init.quo = '0;
        n_d1[0] = d1_stage(init);
        for (int k = 1; k < D1_ST; k++) begin
            n_d1[k] = d1_stage(r_d1[k-1]);
        end
    end

    // Classify SNR against the table span; a zero noise floor lands high.
    always_comb begin
        logic [29:0] snr;
        logic [29:0] diff;
        snr  = r_d1[D1_ST-1].quo;
        diff = snr - sbng_pkg::SNR_LOW;
        n_c.ctx  = r_d1[D1_ST-1].ctx;
        n_c.diff = diff[18:0];
        if (snr < sbng_pkg::SNR_LOW) begin
            n_c.cls = sbng_pkg::CLS_LOW;
        end else if (snr > sbng_pkg::SNR_HIGH) begin
            n_c.cls = sbng_pkg::CLS_HIGH;
        end else begin
            n_c.cls = sbng_pkg::CLS_TABLE;
        end
    end

    // Table index: (snr - low) / step as a multiply by the scaled reciprocal.
    // Exact over the table span, where diff * (rcp*818 - 2^29) stays below 2^29.
    always_comb begin
        logic [38:0] prod;
        prod = {20'd0, r_c.diff} * {19'd0, sbng_pkg::IX_RCP};
        n_d2[0].ctx = r_c.ctx;
        n_d2[0].cls = r_c.cls;
        n_d2[0].quo = prod[37:29];
    end

    // Threshold select.
    always_comb begin
        logic [8:0] ix;
        ix = (r_d2[D2_ST-1].quo > sbng_pkg::TABLE_LAST) ? sbng_pkg::TABLE_LAST
                                                        : r_d2[D2_ST-1].quo;
        n_d.ctx = r_d2[D2_ST-1].ctx;
        if (r_fixed_thr != 4'd0) begin
            n_d.thr = {r_fixed_thr, 15'd0} - {15'd0, r_fixed_thr};
        end else begin
            case (r_d2[D2_ST-1].cls)
                sbng_pkg::CLS_LOW:   n_d.thr = sbng_pkg::THR_HIGH;
                sbng_pkg::CLS_HIGH:  n_d.thr = sbng_pkg::THR_LOW;
                sbng_pkg::CLS_TABLE: n_d.thr = {1'b0, sbng_pkg::THR_TABLE[ix]};
                default:             n_d.thr = sbng_pkg::THR_LOW;
            endcase
        end
    end

    // Threshold times noise floor.
    always_comb begin
        n_e.ctx  = r_d.ctx;
        n_e.prod = {15'd0, r_d.thr} * {19'd0, r_d.ctx.nd};
    end

    // Gain divider stages; the quotient stays below 2^19 since nd <= s.
    always_comb begin
        sbng_pkg::t_d3 init;
        init.ctx = r_e.ctx;
        init.rem = {1'b0, r_e.prod[33:20]};
        init.num = r_e.prod[19:0];
        init.quo = '0;
        n_d3[0] = d3_stage(init);
        for (int k = 1; k < D3_ST; k++) begin
            n_d3[k] = d3_stage(r_d3[k-1]);
        end
    end

    // Gain: a zero signal divides to all ones and gates fully.
    always_comb begin
        logic [19:0] qt;
        logic [19:0] gfull;
        qt    = r_d3[D3_ST-1].quo;
        gfull = {5'd0, sbng_pkg::UNITY} - qt;
        n_f.in_i = r_d3[D3_ST-1].ctx.in_i;
        n_f.in_q = r_d3[D3_ST-1].ctx.in_q;
        n_f.gain = (qt >= {5'd0, sbng_pkg::UNITY}) ? 15'd0 : gfull[14:0];
    end

    // Scale I and Q.
    always_comb begin
        n_g.pi   = 32'(r_f.in_i) * 32'($signed({1'b0, r_f.gain}));
        n_g.pq   = 32'(r_f.in_q) * 32'($signed({1'b0, r_f.gain}));
        n_g.gain = r_f.gain;
    end

    // Floor shift by 15.
    always_comb begin
        n_out.out_i = r_g.pi[30:15];
        n_out.out_q = r_g.pq[30:15];
        n_out.gain  = r_g.gain;
    end

    // Payload pipeline: advance together.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a <= n_a;
            r_b <= n_b;
            for (int k = 0; k < D1_ST; k++) begin
                r_d1[k] <= n_d1[k];
            end
            r_c <= n_c;
            for (int k = 0; k < D2_ST; k++) begin
                r_d2[k] <= n_d2[k];
            end
            r_d <= n_d;
            r_e <= n_e;
            for (int k = 0; k < D3_ST; k++) begin
                r_d3[k] <= n_d3[k];
            end
            r_f   <= n_f;
            r_g   <= n_g;
            r_out <= n_out;
        end
        r_fwd_addr <= r_a.addr;
        r_fwd_word <= upd_state;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_fwd_v       <= 1'b0;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
            r_noise_shift <= sbng_pkg::NOISE_SHIFT_RST;
            r_fixed_thr   <= sbng_pkg::FIXED_THR_RST;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[LAT-2:0], acc};
            end
            // Forward only the write that lands on the same edge as the read.
            r_fwd_v <= adv && r_vld[V_A];
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(BINS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    sbng_pkg::CFG_NOISE_SHIFT: r_noise_shift <= i_cfg_wdata;
                    sbng_pkg::CFG_FIXED_THR:   r_fixed_thr   <= i_cfg_wdata;
                endcase
            end
        end
    end

    // Assertions
    logic frozen_a;
    logic out_muted;
    assign frozen_a  = r_vld[V_A] && !adv;
    assign out_muted = (o_data.out_i == 16'sd0) && (o_data.out_q == 16'sd0);

    `SBNG_ASSERT(a_clear_blocks_input, !(r_clr_busy && acc), "word accepted during clear")
    `SBNG_ASSERT(a_noise_below_signal, !r_vld[V_B] || (r_b.nd <= r_b.sig), "noise above signal")
    `SBNG_ASSERT(a_zero_gain_mutes, !o_valid || (o_data.gain != 15'd0) || out_muted, "unmuted")
    `SBNG_ASSERT_NEXT(a_frozen_holds_bin, frozen_a, r_vld[V_A] && $stable(r_a.addr), "bin moved")

endmodule

`default_nettype wire
